>>> rtl/delimiter_message_framer_macros.svh
// assertion macros shared by the delimiter message framer rtl
// the using module must have clk and arst_n in scope
`ifndef DELIMITER_MESSAGE_FRAMER_MACROS_SVH
`define DELIMITER_MESSAGE_FRAMER_MACROS_SVH
`ifndef SYNTH
`define DMF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define DMF_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define DMF_ASSERT(lbl, prop, msg)
`define DMF_NEVER(lbl, cond, msg)
`endif
`endif

>>> rtl/dmf_pkg.sv
// constants, types and register codes of the delimiter message framer
// no dependencies; dmf_front, dmf_queue, dmf_back and the top level refer to it by scoped names
package dmf_pkg;

	localparam int BUFFER_DEPTH  = 64;
	localparam int MAX_DELIM_LEN = 8;
	localparam int BYTE_W        = 8;
	localparam int POS_W         = $clog2(BUFFER_DEPTH + 1);
	localparam int RING_DEPTH    = 2 * BUFFER_DEPTH;
	localparam int RING_AW       = $clog2(RING_DEPTH);
	localparam int PTR_W         = RING_AW + 1;
	localparam int TAIL_W        = BYTE_W * MAX_DELIM_LEN;
	localparam int DLEN_W        = 4;
	localparam int CFG_W         = 64;
	localparam int CFG_IDX_W     = 1;
	localparam int MSGLEN_W      = 7;
	localparam int QUEUE_DEPTH   = 4;
	localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);
	localparam int CMP_W         = (POS_W > DLEN_W) ? POS_W : DLEN_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DELIM_LEN   = 1'b0,
		REG_DELIM_BYTES = 1'b1
	} cfg_reg_t;

	// ring buffer write request from the front end
	typedef struct packed {
		logic               en;
		logic [RING_AW-1:0] addr;
		logic [BYTE_W-1:0]  data;
	} ram_wr_t;

	// ring buffer read request from the back end
	typedef struct packed {
		logic               en;
		logic [RING_AW-1:0] addr;
	} ram_rd_t;

	// one framed message waiting to be sent
	typedef struct packed {
		logic [POS_W-1:0] len;
	} desc_t;

endpackage

>>> rtl/dmf_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module dmf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/dmf_front.sv
// front end: takes received bytes, writes them to the ring, detects the delimiter
// depends on dmf_pkg and delimiter_message_framer_macros.svh
`include "delimiter_message_framer_macros.svh"
module dmf_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [dmf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dmf_pkg::CFG_W-1:0]    cfg_data,
	input  logic                         rx_valid,
	output logic                         rx_stall,
	input  logic [dmf_pkg::BYTE_W-1:0]   rx_byte,
	input  logic [dmf_pkg::PTR_W-1:0]    rd_ptr,
	output dmf_pkg::ram_wr_t             ram_wr,
	output logic                         push,
	output dmf_pkg::desc_t               push_desc,
	input  logic                         q_full
);

	logic [dmf_pkg::DLEN_W-1:0]        delim_len_q;
	logic [dmf_pkg::TAIL_W-1:0]        delim_q;
	logic [dmf_pkg::POS_W-1:0]         pos_q;
	logic [dmf_pkg::PTR_W-1:0]         base_q;
	logic [dmf_pkg::TAIL_W-1:0]        tail_q;

	logic                              in_acc;
	logic [dmf_pkg::PTR_W-1:0]         wr_abs;
	logic [dmf_pkg::PTR_W-1:0]         used;
	logic                              ring_full;
	logic [dmf_pkg::POS_W-1:0]         new_pos;
	logic [dmf_pkg::TAIL_W-1:0]        new_tail;
	logic                              overflow;
	logic [dmf_pkg::DLEN_W-1:0]        len_eff;
	logic [dmf_pkg::MAX_DELIM_LEN-1:0] lane_ok;
	logic                              match;

	// free space in the ring is measured against the back end's read pointer
	assign wr_abs    = base_q + dmf_pkg::PTR_W'(pos_q);
	assign used      = wr_abs - rd_ptr;
	assign ring_full = (used == dmf_pkg::PTR_W'(dmf_pkg::RING_DEPTH));
	assign rx_stall  = ring_full || q_full;
	assign in_acc    = rx_valid && !rx_stall;

	assign ram_wr.en   = in_acc;
	assign ram_wr.addr = wr_abs[dmf_pkg::RING_AW-1:0];
	assign ram_wr.data = rx_byte;

	assign new_pos  = pos_q + 1'b1;
	assign new_tail = dmf_pkg::TAIL_W'({tail_q, rx_byte});
	assign overflow = (new_pos == dmf_pkg::POS_W'(dmf_pkg::BUFFER_DEPTH));

	assign len_eff = (delim_len_q > dmf_pkg::DLEN_W'(dmf_pkg::MAX_DELIM_LEN)) ?
		dmf_pkg::DLEN_W'(dmf_pkg::MAX_DELIM_LEN) : delim_len_q;

	// byte lanes beyond the delimiter length always pass
	always_comb begin
		for (int j = 0; j < dmf_pkg::MAX_DELIM_LEN; j++) begin
			lane_ok[j] = (dmf_pkg::DLEN_W'(j) >= len_eff) ||
				(new_tail[dmf_pkg::BYTE_W*j +: dmf_pkg::BYTE_W] ==
				 delim_q[dmf_pkg::BYTE_W*j +: dmf_pkg::BYTE_W]);
		end
	end

	assign match = (len_eff != '0) &&
		(dmf_pkg::CMP_W'(new_pos) >= dmf_pkg::CMP_W'(len_eff)) && (&lane_ok);

	assign push          = in_acc && !overflow && match;
	assign push_desc.len = new_pos;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_len_q <= dmf_pkg::DLEN_W'(1);
			delim_q     <= dmf_pkg::TAIL_W'(10);
		end else if (cfg_we) begin
			unique case (dmf_pkg::cfg_reg_t'(cfg_index))
				dmf_pkg::REG_DELIM_LEN:   delim_len_q <= cfg_data[dmf_pkg::DLEN_W-1:0];
				dmf_pkg::REG_DELIM_BYTES: delim_q     <= cfg_data[dmf_pkg::TAIL_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			base_q <= '0;
			tail_q <= '0;
		end else if (in_acc) begin
			if (overflow || match) begin
				pos_q  <= '0;
				tail_q <= '0;
				if (!overflow) begin
					base_q <= wr_abs + 1'b1;
				end
			end else begin
				pos_q  <= new_pos;
				tail_q <= new_tail;
			end
		end
	end

	`DMF_NEVER(a_pos_range, pos_q >= dmf_pkg::POS_W'(dmf_pkg::BUFFER_DEPTH), "fill count past depth")
	`DMF_NEVER(a_ring_overrun, used > dmf_pkg::PTR_W'(dmf_pkg::RING_DEPTH), "ring over-committed")

endmodule

>>> rtl/dmf_queue.sv
// small descriptor queue between the front end and the back end
// depends on dmf_pkg and delimiter_message_framer_macros.svh
`include "delimiter_message_framer_macros.svh"
module dmf_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  dmf_pkg::desc_t push_desc,
	output logic           full,
	input  logic           pop,
	output dmf_pkg::desc_t pop_desc,
	output logic           empty
);

	dmf_pkg::desc_t                entries_q [dmf_pkg::QUEUE_DEPTH];
	logic [dmf_pkg::QUEUE_AW-1:0]  wr_q;
	logic [dmf_pkg::QUEUE_AW-1:0]  rd_q;
	logic [dmf_pkg::QUEUE_AW:0]    count_q;

	assign full     = (count_q == (dmf_pkg::QUEUE_AW+1)'(dmf_pkg::QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_desc = entries_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`DMF_NEVER(a_q_overflow, push && full && !pop, "descriptor queue overflow")
	`DMF_NEVER(a_q_underflow, pop && empty, "descriptor queue underflow")

endmodule

>>> rtl/dmf_back.sv
// back end: reads framed messages out of the ring and sends them byte by byte
// depends on dmf_pkg and delimiter_message_framer_macros.svh
`include "delimiter_message_framer_macros.svh"
module dmf_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_empty,
	input  dmf_pkg::desc_t                q_desc,
	output logic                          q_pop,
	output dmf_pkg::ram_rd_t              ram_rd,
	input  logic [dmf_pkg::BYTE_W-1:0]    ram_rdata,
	output logic [dmf_pkg::PTR_W-1:0]     rd_ptr,
	output logic                          msg_valid,
	input  logic                          msg_stall,
	output logic [dmf_pkg::BYTE_W-1:0]    msg_byte,
	output logic [dmf_pkg::MSGLEN_W-1:0]  msg_length,
	output logic                          msg_last
);

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_DRAIN = 2'b10
	} back_state_t;

	back_state_t                  state_q;
	logic [dmf_pkg::POS_W-1:0]    len_q;
	logic [dmf_pkg::POS_W-1:0]    cnt_q;
	logic [dmf_pkg::PTR_W-1:0]    rd_ptr_q;
	logic                         rd_pend_q;
	logic                         pend_last_q;
	logic [dmf_pkg::POS_W-1:0]    pend_len_q;
	logic                         out_valid_q;
	logic [dmf_pkg::BYTE_W-1:0]   out_byte_q;
	logic [dmf_pkg::MSGLEN_W-1:0] out_len_q;
	logic                         out_last_q;

	logic                         out_acc;
	logic                         issue;
	logic                         last_issue;

	assign out_acc = out_valid_q && !msg_stall;
	// a read is launched only when the output register is sure to be free on return
	assign issue      = (state_q == ST_DRAIN) && !rd_pend_q && (!out_valid_q || out_acc);
	assign last_issue = ((cnt_q + 1'b1) == len_q);
	assign q_pop      = (state_q == ST_IDLE) && !q_empty;

	assign ram_rd.en   = issue;
	assign ram_rd.addr = rd_ptr_q[dmf_pkg::RING_AW-1:0];
	assign rd_ptr      = rd_ptr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (issue && last_issue) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			len_q <= q_desc.len;
			cnt_q <= '0;
		end else if (issue) begin
			cnt_q <= cnt_q + 1'b1;
		end
		if (issue) begin
			pend_last_q <= last_issue;
			pend_len_q  <= len_q;
		end
		if (rd_pend_q) begin
			out_byte_q <= ram_rdata;
			out_len_q  <= dmf_pkg::MSGLEN_W'(pend_len_q);
			out_last_q <= pend_last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q    <= '0;
			rd_pend_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_pend_q <= issue;
			if (issue) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (rd_pend_q) begin
				out_valid_q <= 1'b1;
			end else if (out_acc) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign msg_valid  = out_valid_q;
	assign msg_byte   = out_byte_q;
	assign msg_length = out_len_q;
	assign msg_last   = out_last_q;

	`DMF_ASSERT(a_read_lands, rd_pend_q |=> out_valid_q, "read data found no output slot")
	`DMF_NEVER(a_drain_bound, (state_q == ST_DRAIN) && (cnt_q >= len_q), "drain past message end")

endmodule

>>> rtl/delimiter_message_framer.sv
// top level of the delimiter message framer
// depends on dmf_pkg, dmf_ram, dmf_front, dmf_queue and dmf_back
//
// receives bytes on the rx channel and frames them into messages that end in a
// configurable delimiter of one to eight bytes (delim_len, delim_bytes, final byte
// in the low byte). each complete message, delimiter included, is sent on the msg
// channel one byte per transaction with its total length and a last flag on the
// final byte. a byte that brings a partial message to 64 bytes drops that message
// silently, even if it completes the delimiter; a zero delimiter length never
// matches and lengths above eight act as eight. rate: the front end accepts one
// rx byte per cycle; it stalls rx only while the 128 byte ring buffer is full of
// unread data or the four entry message queue is full. each back end ring read
// passes the registered read port into the single output register before the next
// is issued; draining runs alongside collection of the next message. no clearing
// pass after reset: the ring is only read where it was written. the user must
// write configuration only while the block is idle; the block does not check it.
module delimiter_message_framer (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write port
	input  logic                           cfg_we,
	input  logic [dmf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dmf_pkg::CFG_W-1:0]      cfg_data,
	// received byte channel
	input  logic                           rx_valid,
	output logic                           rx_stall,
	input  logic [dmf_pkg::BYTE_W-1:0]     rx_byte,
	// message byte channel
	output logic                           msg_valid,
	input  logic                           msg_stall,
	output logic [dmf_pkg::BYTE_W-1:0]     msg_byte,
	output logic [dmf_pkg::MSGLEN_W-1:0]   msg_length,
	output logic                           msg_last
);

	dmf_pkg::ram_wr_t               ram_wr;
	dmf_pkg::ram_rd_t               ram_rd;
	logic [dmf_pkg::BYTE_W-1:0]     ram_rdata;
	logic [dmf_pkg::PTR_W-1:0]      rd_ptr;
	logic                           push;
	dmf_pkg::desc_t                 push_desc;
	logic                           q_full;
	logic                           q_pop;
	dmf_pkg::desc_t                 q_desc;
	logic                           q_empty;

	// message bytes live in a ring twice the message depth so that the next
	// message can collect while the previous one is still being sent
	dmf_ram #(
		.WIDTH (dmf_pkg::BYTE_W),
		.DEPTH (dmf_pkg::RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ram_wr.en),
		.waddr (ram_wr.addr),
		.wdata (ram_wr.data),
		.re    (ram_rd.en),
		.raddr (ram_rd.addr),
		.rdata (ram_rdata)
	);

	// front end: byte intake, overflow drop and delimiter detection
	dmf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rx_valid  (rx_valid),
		.rx_stall  (rx_stall),
		.rx_byte   (rx_byte),
		.rd_ptr    (rd_ptr),
		.ram_wr    (ram_wr),
		.push      (push),
		.push_desc (push_desc),
		.q_full    (q_full)
	);

	// framed message lengths handed from front to back
	dmf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.full      (q_full),
		.pop       (q_pop),
		.pop_desc  (q_desc),
		.empty     (q_empty)
	);

	// back end: reads each message out of the ring in arrival order
	dmf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_desc     (q_desc),
		.q_pop      (q_pop),
		.ram_rd     (ram_rd),
		.ram_rdata  (ram_rdata),
		.rd_ptr     (rd_ptr),
		.msg_valid  (msg_valid),
		.msg_stall  (msg_stall),
		.msg_byte   (msg_byte),
		.msg_length (msg_length),
		.msg_last   (msg_last)
	);

endmodule
